/* rtl/fcsr_pkg.sv */
// shared types, constants and function of the filled circle span rasterizer
package fcsr_pkg;

  localparam int MAX_RADIUS  = 31;
  localparam int COORD_W     = 13;
  localparam int COORD_EXT_W = COORD_W + 1;
  localparam int RADIUS_W    = 5;
  localparam int OFFSET_W    = RADIUS_W + 1;
  localparam int REM_W       = 2 * RADIUS_W;
  localparam int COLOR_W     = 32;
  localparam int SCREEN_W    = 12;
  localparam int PIX_W       = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = SCREEN_W;

  localparam logic [SCREEN_W-1:0] SCREEN_LIMIT = SCREEN_W'(2048);
  localparam logic [SCREEN_W-1:0] WIDTH_RESET  = SCREEN_W'(640);
  localparam logic [SCREEN_W-1:0] HEIGHT_RESET = SCREEN_W'(480);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new circle, clear the row offset
    logic issue;  // push the current row offset into the span pipeline
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_offset;  // current row offset is the final one of the circle
    logic advance;      // span pipeline moves this cycle
  } dp_status_t;

  // floor square root, one result bit per step
  function automatic logic [RADIUS_W-1:0] isqrt(input logic [REM_W-1:0] n);
    logic [RADIUS_W-1:0] res;
    logic [RADIUS_W-1:0] trial;
    logic [REM_W-1:0]    sq;
    res = '0;
    for (int i = RADIUS_W - 1; i >= 0; i--) begin
      trial = res | (RADIUS_W'(1) << i);
      sq    = REM_W'(trial) * REM_W'(trial);
      if (sq <= n) begin
        res = trial;
      end
    end
    return res;
  endfunction

endpackage

/* rtl/fcsr_if.sv */
// channel interfaces: circle input, span output and configuration write
interface fcsr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcsr_pkg::COORD_W-1:0] center_x;
  logic signed [fcsr_pkg::COORD_W-1:0] center_y;
  logic [fcsr_pkg::RADIUS_W-1:0]       radius;
  logic [fcsr_pkg::COLOR_W-1:0]        fill_color;

  modport source (output valid, center_x, center_y, radius, fill_color, input ready);
  modport sink   (input valid, center_x, center_y, radius, fill_color, output ready);
endinterface

interface fcsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [fcsr_pkg::PIX_W-1:0]   row;
  logic [fcsr_pkg::PIX_W-1:0]   x_first;
  logic [fcsr_pkg::PIX_W-1:0]   x_final;
  logic [fcsr_pkg::COLOR_W-1:0] pixel_value;
  logic                         visible;
  logic                         last;

  modport source (output valid, row, x_first, x_final, pixel_value, visible, last,
                  input ready);
  modport sink   (input valid, row, x_first, x_final, pixel_value, visible, last,
                  output ready);
endinterface

interface fcsr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fcsr_pkg::CFG_INDEX_W-1:0] index;
  logic [fcsr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/filled_circle_span_rasterizer_core.sv */
// top level of the filled circle span rasterizer
//
// usage:
//   circle channel: one item is a circle (center_x, center_y, radius, fill_color)
//   span channel: 2*radius+1 items per circle, top row first, last set on the
//     bottom row; hidden spans carry visible = 0 and zero coordinates
//   cfg channel: index 0 writes screen_width, index 1 screen_height; always
//     ready, write only while no circle is in flight
// timing:
//   a circle is taken while the sequencer is idle, then one row offset enters the span
//   pipeline per cycle unless the span channel stalls; the next circle is taken right
//   after the last row is issued
//   the first span passes the circle registers, stage 1 (remaining square), stage 2
//   (square root) and stage 3 (clip into the output register) before it is valid
//   the square root is a 5-step compare over 10 bits in pipeline stage 2
// reset: sequencer idle, pipeline empty, screen back to 640 x 480
// stall: a low ready on the span channel while a span is valid freezes the whole
//   pipeline and the row walk of the sequencer; nothing is dropped or repeated
module filled_circle_span_rasterizer_core (
  input  logic       clk,
  input  logic       rst,
  fcsr_in_if.sink    circle,
  fcsr_out_if.source span,
  fcsr_cfg_if.sink   cfg
);

  fcsr_pkg::ctrl_cmd_t  cmd;
  fcsr_pkg::dp_status_t status;

  // configuration registers never back-pressure
  assign cfg.ready = 1'b1;

  // row sequencer
  fcsr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .circle_valid (circle.valid),
    .circle_ready (circle.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // circle registers, span pipeline and output register
  fcsr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .center_x    (circle.center_x),
    .center_y    (circle.center_y),
    .radius      (circle.radius),
    .fill_color  (circle.fill_color),
    .cfg_write   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .span_valid  (span.valid),
    .span_ready  (span.ready),
    .row         (span.row),
    .x_first     (span.x_first),
    .x_final     (span.x_final),
    .pixel_value (span.pixel_value),
    .visible     (span.visible),
    .last        (span.last)
  );

endmodule

/* rtl/fcsr_ctrl.sv */
// controller: walks the row offsets of one circle
module fcsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 circle_valid,
  output logic                 circle_ready,
  input  fcsr_pkg::dp_status_t status,
  output fcsr_pkg::ctrl_cmd_t  cmd
);

  fcsr_pkg::state_t state;
  fcsr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    circle_ready = 1'b0;
    cmd          = '0;
    case (state)
      fcsr_pkg::ST_IDLE: begin
        circle_ready = 1'b1;
        if (circle_valid) begin
          cmd.load   = 1'b1;
          state_next = fcsr_pkg::ST_RUN;
        end
      end
      fcsr_pkg::ST_RUN: begin
        cmd.issue = status.advance;
        if (status.advance && status.last_offset) begin
          state_next = fcsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fcsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/fcsr_datapath.sv */
// datapath: held circle, screen registers and three-stage span pipeline
module fcsr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  fcsr_pkg::ctrl_cmd_t                 cmd,
  output fcsr_pkg::dp_status_t                status,
  input  logic signed [fcsr_pkg::COORD_W-1:0] center_x,
  input  logic signed [fcsr_pkg::COORD_W-1:0] center_y,
  input  logic [fcsr_pkg::RADIUS_W-1:0]       radius,
  input  logic [fcsr_pkg::COLOR_W-1:0]        fill_color,
  input  logic                                cfg_write,
  input  logic [fcsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fcsr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                span_valid,
  input  logic                                span_ready,
  output logic [fcsr_pkg::PIX_W-1:0]          row,
  output logic [fcsr_pkg::PIX_W-1:0]          x_first,
  output logic [fcsr_pkg::PIX_W-1:0]          x_final,
  output logic [fcsr_pkg::COLOR_W-1:0]        pixel_value,
  output logic                                visible,
  output logic                                last
);

  // screen size registers
  logic [fcsr_pkg::SCREEN_W-1:0] screen_width;
  logic [fcsr_pkg::SCREEN_W-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= fcsr_pkg::WIDTH_RESET;
      screen_height <= fcsr_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (fcsr_pkg::cfg_reg_t'(cfg_index))
        fcsr_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        fcsr_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic [fcsr_pkg::SCREEN_W-1:0] w_clip;
  logic [fcsr_pkg::SCREEN_W-1:0] h_clip;
  assign w_clip = (screen_width  > fcsr_pkg::SCREEN_LIMIT) ? fcsr_pkg::SCREEN_LIMIT
                                                           : screen_width;
  assign h_clip = (screen_height > fcsr_pkg::SCREEN_LIMIT) ? fcsr_pkg::SCREEN_LIMIT
                                                           : screen_height;

  // held circle and row offset counter
  logic signed [fcsr_pkg::COORD_W-1:0] held_center_x;
  logic signed [fcsr_pkg::COORD_W-1:0] held_center_y;
  logic [fcsr_pkg::RADIUS_W-1:0]       held_radius;
  logic [fcsr_pkg::COLOR_W-1:0]        held_color;
  logic [fcsr_pkg::OFFSET_W-1:0]       row_offset;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_center_x <= center_x;
      held_center_y <= center_y;
      held_radius   <= radius;
      held_color    <= fill_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_offset <= '0;
    end else if (cmd.load) begin
      row_offset <= '0;
    end else if (cmd.issue) begin
      row_offset <= row_offset + fcsr_pkg::OFFSET_W'(1);
    end
  end

  logic advance;
  assign advance            = !span_valid || span_ready;
  assign status.advance     = advance;
  assign status.last_offset = (row_offset == {held_radius, 1'b0});

  // stage 1: remaining square and row
  logic [fcsr_pkg::OFFSET_W-1:0]           radius_ext;
  logic [fcsr_pkg::RADIUS_W-1:0]           abs_dy;
  logic signed [fcsr_pkg::OFFSET_W:0]      dy;
  logic [fcsr_pkg::REM_W-1:0]              rr;
  logic [fcsr_pkg::REM_W-1:0]              yy;

  assign radius_ext = {1'b0, held_radius};
  assign abs_dy = (row_offset >= radius_ext) ?
                  fcsr_pkg::RADIUS_W'(row_offset - radius_ext) :
                  fcsr_pkg::RADIUS_W'(radius_ext - row_offset);
  assign dy = $signed({1'b0, row_offset}) - $signed({2'b00, held_radius});
  assign rr = fcsr_pkg::REM_W'(held_radius) * fcsr_pkg::REM_W'(held_radius);
  assign yy = fcsr_pkg::REM_W'(abs_dy) * fcsr_pkg::REM_W'(abs_dy);

  logic                                    s1_valid;
  logic [fcsr_pkg::REM_W-1:0]              s1_rem;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] s1_py;
  logic signed [fcsr_pkg::COORD_W-1:0]     s1_cx;
  logic [fcsr_pkg::COLOR_W-1:0]            s1_color;
  logic                                    s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_rem   <= rr - yy;
      s1_py    <= fcsr_pkg::COORD_EXT_W'(held_center_y) + fcsr_pkg::COORD_EXT_W'(dy);
      s1_cx    <= held_center_x;
      s1_color <= held_color;
      s1_last  <= status.last_offset;
    end
  end

  // stage 2: half-width and span ends
  logic [fcsr_pkg::RADIUS_W-1:0]           half;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] half_ext;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] cx_ext;

  assign half     = fcsr_pkg::isqrt(s1_rem);
  assign half_ext = $signed({{(fcsr_pkg::COORD_EXT_W - fcsr_pkg::RADIUS_W){1'b0}}, half});
  assign cx_ext   = fcsr_pkg::COORD_EXT_W'(s1_cx);

  logic                                    s2_valid;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] s2_py;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] s2_left;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] s2_right;
  logic [fcsr_pkg::COLOR_W-1:0]            s2_color;
  logic                                    s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_py    <= s1_py;
      s2_left  <= cx_ext - half_ext;
      s2_right <= cx_ext + half_ext;
      s2_color <= s1_color;
      s2_last  <= s1_last;
    end
  end

  // stage 3: clipping into the output register
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] w_s;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] h_s;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] w_m1;
  logic                                    vis;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] left_c;
  logic signed [fcsr_pkg::COORD_EXT_W-1:0] right_c;

  assign w_s   = $signed({{(fcsr_pkg::COORD_EXT_W - fcsr_pkg::SCREEN_W){1'b0}}, w_clip});
  assign h_s   = $signed({{(fcsr_pkg::COORD_EXT_W - fcsr_pkg::SCREEN_W){1'b0}}, h_clip});
  assign w_m1  = w_s - fcsr_pkg::COORD_EXT_W'(1);
  assign vis   = (s2_py >= 0) && (s2_py < h_s) && (s2_right >= 0) && (s2_left < w_s);
  assign left_c  = (s2_left < 0) ? '0 : s2_left;
  assign right_c = (s2_right > w_m1) ? w_m1 : s2_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (advance) begin
      span_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row         <= vis ? s2_py[fcsr_pkg::PIX_W-1:0]   : '0;
      x_first     <= vis ? left_c[fcsr_pkg::PIX_W-1:0]  : '0;
      x_final     <= vis ? right_c[fcsr_pkg::PIX_W-1:0] : '0;
      pixel_value <= s2_color;
      visible     <= vis;
      last        <= s2_last;
    end
  end

endmodule
